[rtl/core/cv3_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_pkg: shared types and constants of the 3x3 image filter
// Register indexes, kernel mode codes, window column type and fixed-point
// constants used by the filter datapath.
// ----------------------------------------------------------------------------
package cv3_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int MODE_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int ROW_W     = 10;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_DIM       = 3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd2;

    localparam logic [CFG_W-1:0]  WIDTH_RST  = 11'd512;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 11'd512;

    // kernel mode codes
    localparam logic [MODE_W-1:0] MODE_BOX         = 4'd0;
    localparam logic [MODE_W-1:0] MODE_GAUSS       = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PREWITT_X   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_PREWITT_Y   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_SOBEL_X     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SOBEL_Y     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_LAPLACE     = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SHARPEN     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_PREWITT_MAX = 4'd8;
    localparam logic [MODE_W-1:0] MODE_SOBEL_MAX   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_RST         = MODE_BOX;

    // box: floor(s * 0.11111) == (s * BOX_MUL) >> BOX_SHIFT for s <= 2295
    localparam int                BOX_MUL_W = 25;
    localparam logic [BOX_MUL_W-1:0] BOX_MUL = 25'd29825864;
    localparam int                BOX_SHIFT = 28;
    localparam int                SUM_W     = 12;
    localparam int                BOX_PW    = SUM_W + BOX_MUL_W;

    // floor(a / 3) == (a * DIV3_MUL) >> DIV3_SHIFT for a <= 765
    localparam int                DIV3_PW    = 20;
    localparam logic [DIV3_PW-1:0] DIV3_MUL  = 20'd683;
    localparam int                DIV3_SHIFT = 11;

    localparam int NUM_CELLS   = 2;
    localparam int OFIFO_DEPTH = 8;

    // one window column with its plain and 1-2-1 weighted sums
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        logic [9:0]       csum;
        logic [9:0]       wsum;
    } column_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } out_item_t;

    function automatic column_t make_column(input logic [PIX_W-1:0] top,
                                            input logic [PIX_W-1:0] mid,
                                            input logic [PIX_W-1:0] bot);
        column_t c;
        c.top  = top;
        c.mid  = mid;
        c.bot  = bot;
        c.csum = 10'(top) + 10'(mid) + 10'(bot);
        c.wsum = 10'(top) + (10'(mid) << 1) + 10'(bot);
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/core/cv3_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/core/cv3_col_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_col_cell: one column cell of the 3x3 window
// Holds one window column and hands it to the next older cell on a shift.
// ----------------------------------------------------------------------------
module cv3_col_cell (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire cv3_pkg::column_t col_in,
    output cv3_pkg::column_t      col_out
);
    import cv3_pkg::*;

    column_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule
`default_nettype wire

[rtl/core/cv3_kernel.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_kernel: kernel arithmetic of the 3x3 filter
// Two register stages: window sums and gradients, then abs, scaling and
// clamping; the mode select at the end feeds the output queue.
// ----------------------------------------------------------------------------
module cv3_kernel (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cv3_pkg::tag_t                  win_tag,
    input  wire cv3_pkg::column_t               col_l,
    input  wire cv3_pkg::column_t               col_m,
    input  wire cv3_pkg::column_t               col_r,
    input  wire logic [cv3_pkg::MODE_W-1:0]     kernel_mode,
    output cv3_pkg::tag_t                       res_tag,
    output logic      [cv3_pkg::PIX_W-1:0]      res_pixel
);
    import cv3_pkg::*;

    // stage a: sums and gradients
    logic [9:0]        top_row, bot_row, top_w, bot_w;
    logic [SUM_W-1:0]  sum9, gauss, c9, c10;
    logic signed [10:0] pgx, pgy, sgx, sgy;
    logic signed [12:0] lap, sharp;

    tag_t               ka_tag_reg;
    logic [SUM_W-1:0]   ka_sum9_reg, ka_gauss_reg;
    logic signed [10:0] ka_pgx_reg, ka_pgy_reg, ka_sgx_reg, ka_sgy_reg;
    logic signed [12:0] ka_lap_reg, ka_sharp_reg;

    // stage b: scaled magnitudes
    logic [9:0]         pa_abs, pb_abs, sa_abs, sb_abs;
    logic [11:0]        lap_abs;
    logic [DIV3_PW-1:0] pa_prod, pb_prod;
    logic [BOX_PW-1:0]  box_prod;
    logic [PIX_W-1:0]   sharp_clip;

    tag_t             kb_tag_reg;
    logic [PIX_W-1:0] kb_box_reg, kb_gauss_reg, kb_pa_reg, kb_pb_reg;
    logic [PIX_W-1:0] kb_sa_reg, kb_sb_reg, kb_lap_reg, kb_sharp_reg;

    logic [PIX_W-1:0] result;

    always_comb
    begin
        top_row = 10'(col_l.top) + 10'(col_m.top) + 10'(col_r.top);
        bot_row = 10'(col_l.bot) + 10'(col_m.bot) + 10'(col_r.bot);
        top_w   = 10'(col_l.top) + (10'(col_m.top) << 1) + 10'(col_r.top);
        bot_w   = 10'(col_l.bot) + (10'(col_m.bot) << 1) + 10'(col_r.bot);
        sum9    = SUM_W'(col_l.csum) + SUM_W'(col_m.csum) + SUM_W'(col_r.csum);
        gauss   = SUM_W'(col_l.wsum) + (SUM_W'(col_m.wsum) << 1) + SUM_W'(col_r.wsum);
        pgx     = $signed({1'b0, col_r.csum}) - $signed({1'b0, col_l.csum});
        pgy     = $signed({1'b0, bot_row}) - $signed({1'b0, top_row});
        sgx     = $signed({1'b0, col_r.wsum}) - $signed({1'b0, col_l.wsum});
        sgy     = $signed({1'b0, bot_w}) - $signed({1'b0, top_w});
        c9      = (SUM_W'(col_m.mid) << 3) + SUM_W'(col_m.mid);
        c10     = c9 + SUM_W'(col_m.mid);
        lap     = $signed({1'b0, c9}) - $signed({1'b0, sum9});
        sharp   = $signed({1'b0, c10}) - $signed({1'b0, sum9});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ka_tag_reg <= '0;
            kb_tag_reg <= '0;
        end
        else
        begin
            ka_tag_reg <= win_tag;
            kb_tag_reg <= ka_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ka_sum9_reg  <= sum9;
        ka_gauss_reg <= gauss;
        ka_pgx_reg   <= pgx;
        ka_pgy_reg   <= pgy;
        ka_sgx_reg   <= sgx;
        ka_sgy_reg   <= sgy;
        ka_lap_reg   <= lap;
        ka_sharp_reg <= sharp;
    end

    always_comb
    begin
        pa_abs   = ka_pgx_reg[10] ? 10'(-ka_pgx_reg) : 10'(ka_pgx_reg);
        pb_abs   = ka_pgy_reg[10] ? 10'(-ka_pgy_reg) : 10'(ka_pgy_reg);
        sa_abs   = ka_sgx_reg[10] ? 10'(-ka_sgx_reg) : 10'(ka_sgx_reg);
        sb_abs   = ka_sgy_reg[10] ? 10'(-ka_sgy_reg) : 10'(ka_sgy_reg);
        lap_abs  = ka_lap_reg[12] ? 12'(-ka_lap_reg) : 12'(ka_lap_reg);
        pa_prod  = DIV3_PW'(pa_abs) * DIV3_MUL;
        pb_prod  = DIV3_PW'(pb_abs) * DIV3_MUL;
        box_prod = BOX_PW'(ka_sum9_reg) * BOX_PW'(BOX_MUL);
        if (ka_sharp_reg[12])
        begin
            sharp_clip = '0;
        end
        else if (ka_sharp_reg > 13'sd255)
        begin
            sharp_clip = '1;
        end
        else
        begin
            sharp_clip = ka_sharp_reg[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        kb_box_reg   <= box_prod[BOX_SHIFT +: PIX_W];
        kb_gauss_reg <= ka_gauss_reg[SUM_W-1:4];
        kb_pa_reg    <= pa_prod[DIV3_SHIFT +: PIX_W];
        kb_pb_reg    <= pb_prod[DIV3_SHIFT +: PIX_W];
        kb_sa_reg    <= sa_abs[9:2];
        kb_sb_reg    <= sb_abs[9:2];
        kb_lap_reg   <= lap_abs[10:3];
        kb_sharp_reg <= sharp_clip;
    end

    always_comb
    begin
        case (kernel_mode)
            MODE_BOX:         result = kb_box_reg;
            MODE_GAUSS:       result = kb_gauss_reg;
            MODE_PREWITT_X:   result = kb_pa_reg;
            MODE_PREWITT_Y:   result = kb_pb_reg;
            MODE_SOBEL_X:     result = kb_sa_reg;
            MODE_SOBEL_Y:     result = kb_sb_reg;
            MODE_LAPLACE:     result = kb_lap_reg;
            MODE_SHARPEN:     result = kb_sharp_reg;
            MODE_PREWITT_MAX: result = (kb_pa_reg > kb_pb_reg) ? kb_pa_reg : kb_pb_reg;
            MODE_SOBEL_MAX:   result = (kb_sa_reg > kb_sb_reg) ? kb_sa_reg : kb_sb_reg;
            default:          result = '0;
        endcase
    end

    assign res_tag   = kb_tag_reg;
    assign res_pixel = result;

endmodule
`default_nettype wire

[rtl/core/conv3x3_image_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_image_filter: streaming 3x3 convolution filter for grey pixels
// Line store RAM, a chain of window column cells, a two stage kernel and an
// output queue.
//
//   channel | direction | handshake          | payload
//   pixels  | in        | in_valid/in_stall  | in_pixel
//   results | out       | out_valid/out_stall| out_pixel, frame_end
//   config  | in        | cfg_write          | cfg_index, cfg_data
//
// One item per cycle sustained while in_stall is low; a result passes the stage 1
// registers, both kernel stages and the output queue before it is offered.
// The line store RAM does one read and one write a cycle.
// in_stall rises when 8 results are owed (queued or in flight), so the
// 8-entry queue can hold every owed result while the output side is stalled.
// Reset clears counters and control only; no clearing pass on the RAM.
// ----------------------------------------------------------------------------
module conv3x3_image_filter #(
    parameter int MAX_WIDTH = cv3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [cv3_pkg::PIX_W-1:0]        in_pixel,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [cv3_pkg::PIX_W-1:0]        out_pixel,
    output logic                                  frame_end,
    input  wire logic                             cfg_write,
    input  wire logic [cv3_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [cv3_pkg::CFG_W-1:0]        cfg_data
);
    import cv3_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int QP_W  = $clog2(OFIFO_DEPTH);
    localparam int QC_W  = $clog2(OFIFO_DEPTH + 1);

    // configuration
    logic [CFG_W-1:0]  image_width_reg, image_height_reg;
    logic [MODE_W-1:0] kernel_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            kernel_mode_reg  <= MODE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_KERNEL_MODE:  kernel_mode_reg  <= cfg_data[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    // saturated last column and last row
    logic [WW-1:0]    width_ext, width_sat;
    logic [CW-1:0]    w_last;
    logic [CFG_W-1:0] height_sat;
    logic [ROW_W-1:0] h_last;

    always_comb
    begin
        width_ext = WW'(image_width_reg);
        if (width_ext < WW'(MIN_DIM))
        begin
            width_sat = WW'(MIN_DIM);
        end
        else if (width_ext > WW'(MAX_WIDTH))
        begin
            width_sat = WW'(MAX_WIDTH);
        end
        else
        begin
            width_sat = width_ext;
        end
        w_last = CW'(width_sat - WW'(1));

        if (image_height_reg < CFG_W'(MIN_DIM))
        begin
            height_sat = CFG_W'(MIN_DIM);
        end
        else if (image_height_reg > CFG_W'(MAX_HEIGHT))
        begin
            height_sat = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            height_sat = image_height_reg;
        end
        h_last = ROW_W'(height_sat - CFG_W'(1));
    end

    // position counters
    logic             accept;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             last_col, last_row, produce;
    logic [QC_W-1:0]  credit_reg;

    assign in_stall = (credit_reg >= QC_W'(OFIFO_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        last_col = (col_reg >= w_last);
        last_row = (row_reg >= h_last);
        produce  = (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    // stage 1: line store read data arrives
    logic             s1_valid_reg, s1_produce_reg, s1_last_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= in_pixel;
            s1_col_reg     <= col_reg;
            s1_produce_reg <= produce;
            s1_last_reg    <= last_col && last_row;
        end
    end

    // line store: {older row, newer row} per column
    logic [2*PIX_W-1:0] ls_rdata;

    cv3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({ls_rdata[PIX_W-1:0], s1_pix_reg}),
        .raddr (col_reg),
        .rdata (ls_rdata)
    );

    // window column chain, newest column first
    column_t chain [0:NUM_CELLS];

    assign chain[0] = make_column(ls_rdata[2*PIX_W-1:PIX_W], ls_rdata[PIX_W-1:0],
                                  s1_pix_reg);

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        cv3_col_cell u_cell (
            .clk     (clk),
            .shift   (s1_valid_reg),
            .col_in  (chain[i]),
            .col_out (chain[i+1])
        );
    end

    tag_t             win_tag, res_tag;
    logic [PIX_W-1:0] res_pixel;

    assign win_tag.valid = s1_valid_reg && s1_produce_reg;
    assign win_tag.last  = s1_last_reg;

    cv3_kernel u_kernel (
        .clk         (clk),
        .rst_n       (rst_n),
        .win_tag     (win_tag),
        .col_l       (chain[2]),
        .col_m       (chain[1]),
        .col_r       (chain[0]),
        .kernel_mode (kernel_mode_reg),
        .res_tag     (res_tag),
        .res_pixel   (res_pixel)
    );

    // output queue; credits count results owed, queued or in flight
    out_item_t       q_mem_reg [0:OFIFO_DEPTH-1];
    out_item_t       q_head;
    logic [QP_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0] q_count_reg;
    logic            take;

    assign q_head    = q_mem_reg[rd_ptr_reg];
    assign out_valid = (q_count_reg != '0);
    assign out_pixel = q_head.pixel;
    assign frame_end = q_head.last;
    assign take      = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (res_tag.valid)
        begin
            q_mem_reg[wr_ptr_reg] <= '{pixel: res_pixel, last: res_tag.last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
            credit_reg  <= '0;
        end
        else
        begin
            if (res_tag.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            end
            if (take)
            begin
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            end
            q_count_reg <= q_count_reg + QC_W'(res_tag.valid) - QC_W'(take);
            credit_reg  <= credit_reg + QC_W'(accept && produce) - QC_W'(take);
        end
    end

endmodule
`default_nettype wire
